// ===== rtl/ttt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ttt_pkg;

  localparam int TableDepth = 512;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CntW       = AddrW + 1;
  localparam int NumW       = 44;
  localparam int TempW      = (AddrW + 7 < 15) ? 15 : AddrW + 7;
  localparam int TempMax    = 8191;
  localparam int TempMin    = -8192;
  localparam int StCntW     = $clog2(NumW + 1);

  typedef enum logic [2:0] {
    RegDivider = 3'd0,
    RegSupply  = 3'd1,
    RegLowTemp = 3'd2,
    RegStep    = 3'd3,
    RegEntries = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatRange   = 2'd1,
    StatSupply  = 2'd2
  } status_e;

  typedef struct packed {
    logic [23:0]        divider_ohms;
    logic [15:0]        supply_mv;
    logic signed [9:0]  low_temp;
    logic [4:0]         temp_step;
    logic [9:0]         entries;
  } cfg_t;

  function automatic logic [CntW-1:0] entries_in_use(input logic [9:0] e);
    int n;
    n = int'(e);
    if (n < 2) n = 2;
    if (n > TableDepth) n = TableDepth;
    return CntW'(n);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ttt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttt_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/ttt_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttt_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output ttt_pkg::cfg_t      cfg_o
);

  ttt_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        ttt_pkg::RegDivider: cfg_d.divider_ohms = pwdata[23:0];
        ttt_pkg::RegSupply:  cfg_d.supply_mv    = pwdata[15:0];
        ttt_pkg::RegLowTemp: cfg_d.low_temp     = pwdata[9:0];
        ttt_pkg::RegStep:    cfg_d.temp_step    = pwdata[4:0];
        ttt_pkg::RegEntries: cfg_d.entries      = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ttt_pkg::RegDivider: prdata = {8'd0, cfg_q.divider_ohms};
      ttt_pkg::RegSupply:  prdata = {16'd0, cfg_q.supply_mv};
      ttt_pkg::RegLowTemp: prdata = {22'd0, cfg_q.low_temp};
      ttt_pkg::RegStep:    prdata = {27'd0, cfg_q.temp_step};
      ttt_pkg::RegEntries: prdata = {22'd0, cfg_q.entries};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.divider_ohms <= 24'd10000;
      cfg_q.supply_mv    <= 16'd5000;
      cfg_q.low_temp     <= -10'sd55;
      cfg_q.temp_step    <= 5'd1;
      cfg_q.entries      <= 10'd356;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/ttt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttt_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [ttt_pkg::NumW-1:0]  dividend_i,
  input  wire logic [15:0]               divisor_i,
  output logic                           done_o,
  output logic      [ttt_pkg::NumW-1:0]  quotient_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [ttt_pkg::StCntW-1:0]  cnt_q, cnt_d;
  logic [ttt_pkg::NumW-1:0]    dvd_q, dvd_d;
  logic [15:0]                 rem_q, rem_d;
  logic [15:0]                 dsr_q, dsr_d;
  logic [16:0]                 trial;
  logic                        qbit;

  // one quotient bit a cycle, quotient shifts in where the dividend leaves
  assign trial = {rem_q, dvd_q[ttt_pkg::NumW-1]};
  assign qbit  = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ttt_pkg::StCntW'(ttt_pkg::NumW);
      dvd_d  = dividend_i;
      rem_d  = 16'd0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = qbit ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
      dvd_d = {dvd_q[ttt_pkg::NumW-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ttt_pkg::StCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dsr_q)
    else $error("partial remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a run");

endmodule

`default_nettype wire

// ===== rtl/thermistor_table_temperature.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | contents
// s_axis    | in        | tuser[0] op; tdata entry_address, entry_value, sample_millivolts
// m_axis    | out       | tdata temperature, table_position, resistance, status
// apb       | in / out  | divider_ohms, supply_millivolts, low_temperature, step, entries
//
// a write request is taken while idle and writes can follow back to back
// a convert request starts and runs the 44-step bit-serial divider, skipped on a supply fault,
// then reads the table ends and scans one table word per cycle until a pair's midpoint lies
// beyond the resistance or the last pair is reached
// the table memory has no reset; reset clears control and configuration only
// s_axis_tready is high only between requests; a waiting result stalls only the final step

module thermistor_table_temperature (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // sample_millivolts[56:41] entry_value[40:9] entry_address[8:0]
  input  wire logic [63:0]   s_axis_tdata,
  // op[0]
  input  wire logic [0:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // status[56:55] resistance[54:23] table_position[22:14] temperature[13:0]
  output logic      [63:0]   m_axis_tdata,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DST  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_RD0  = 4'd4;
  localparam logic [3:0] S_RD1  = 4'd5;
  localparam logic [3:0] S_RDL  = 4'd6;
  localparam logic [3:0] S_DIR  = 4'd7;
  localparam logic [3:0] S_SCAN = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam int AddrW = ttt_pkg::AddrW;
  localparam int CntW  = ttt_pkg::CntW;
  localparam int TempW = ttt_pkg::TempW;

  ttt_pkg::cfg_t             cfg;
  logic [3:0]                state_q, state_d;
  logic [15:0]               v_q;
  logic [ttt_pkg::NumW-1:0]  num_q;
  logic [15:0]               dsr_q;
  logic [31:0]               res_q, res_d;
  logic                      sat_q, sat_d;
  logic [31:0]               first_q, last_q, prev_q;
  logic                      desc_q;
  logic [AddrW-1:0]          idx_q, idx_d;
  logic                      m_valid_q;
  logic [63:0]               m_data_q;

  logic                      accept;
  logic                      in_op;
  logic [8:0]                in_addr;
  logic [31:0]               in_value;
  logic [15:0]               in_mv;
  logic                      we;
  logic [AddrW-1:0]          raddr;
  logic [31:0]               rdata;
  logic [CntW-1:0]           n_use;
  logic [CntW-1:0]           n_last;
  logic                      div_start, div_done;
  logic [ttt_pkg::NumW-1:0]  quot;
  logic [32:0]               pair_sum, res_x2;
  logic                      hit;
  logic                      outside;
  logic [1:0]                status;
  logic [AddrW+4:0]          prod;
  logic signed [TempW-1:0]   temp_sum;
  logic [13:0]               temp_sat;
  logic                      out_load;

  ttt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_op    = s_axis_tuser[0];
  assign in_addr  = s_axis_tdata[8:0];
  assign in_value = s_axis_tdata[40:9];
  assign in_mv    = s_axis_tdata[56:41];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign we            = accept & ~in_op & ({23'd0, in_addr} < 32'(ttt_pkg::TableDepth));

  assign n_use  = ttt_pkg::entries_in_use(cfg.entries);
  assign n_last = n_use - 1'b1;

  // the scan reads one word ahead of the pair under test
  always_comb begin
    unique case (state_q)
      S_RD1:   raddr = n_last[AddrW-1:0];
      S_RDL:   raddr = AddrW'(1);
      S_DIR:   raddr = AddrW'(1);
      S_SCAN:  raddr = AddrW'({1'b0, idx_q} + CntW'(2));
      default: raddr = '0;
    endcase
  end

  ttt_ram #(
    .Width (32),
    .Depth (ttt_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AddrW'(in_addr)),
    .wdata_i (in_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign div_start = (state_q == S_DST);

  ttt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_q),
    .divisor_i  (dsr_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign pair_sum = {1'b0, prev_q} + {1'b0, rdata};
  assign res_x2   = {res_q, 1'b0};
  assign hit      = desc_q ? (res_x2 > pair_sum) : (res_x2 < pair_sum);

  assign outside = desc_q ? ((res_q > first_q) || (res_q < last_q))
                          : ((res_q < first_q) || (res_q > last_q));
  assign status  = sat_q   ? ttt_pkg::StatSupply :
                   outside ? ttt_pkg::StatRange  : ttt_pkg::StatOk;

  assign prod     = idx_q * cfg.temp_step;
  assign temp_sum = TempW'(cfg.low_temp) + signed'(TempW'(prod));

  always_comb begin
    if (int'(temp_sum) > ttt_pkg::TempMax) begin
      temp_sat = 14'(ttt_pkg::TempMax);
    end else if (int'(temp_sum) < ttt_pkg::TempMin) begin
      temp_sat = 14'(ttt_pkg::TempMin);
    end else begin
      temp_sat = temp_sum[13:0];
    end
  end

  assign out_load = (state_q == S_DONE) & (~m_valid_q | m_axis_tready);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    sat_d   = sat_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_op) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (v_q >= cfg.supply_mv) begin
          res_d   = '1;
          sat_d   = 1'b1;
          state_d = S_RD0;
        end else begin
          sat_d   = 1'b0;
          state_d = S_DST;
        end
      end
      S_DST: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          res_d   = (|quot[ttt_pkg::NumW-1:32]) ? '1 : quot[31:0];
          state_d = S_RD0;
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: state_d = S_RDL;
      S_RDL: state_d = S_DIR;
      S_DIR: begin
        idx_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_DONE;
        end else if ({1'b0, idx_q} + CntW'(1) == n_last) begin
          idx_d   = n_last[AddrW-1:0];
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    sat_q <= sat_d;
    idx_q <= idx_d;
    if (accept) begin
      v_q <= in_mv;
    end
    if (state_q == S_MUL) begin
      num_q <= {40'(cfg.divider_ohms) * 40'(v_q), 4'd0};
      dsr_q <= cfg.supply_mv - v_q;
    end
    if (state_q == S_RD1) begin
      first_q <= rdata;
    end
    if (state_q == S_RDL) begin
      last_q <= rdata;
    end
    if (state_q == S_DIR) begin
      desc_q <= first_q > rdata;
      prev_q <= first_q;
    end else if (state_q == S_SCAN) begin
      prev_q <= rdata;
    end
    if (out_load) begin
      m_data_q <= {7'd0, status, res_q, 9'(idx_q), temp_sat};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the final step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[56:55] == ttt_pkg::StatSupply) |-> (&m_data_q[54:23]))
    else $error("supply fault without saturated resistance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ({1'b0, idx_q} < n_last))
    else $error("scan index past last pair");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

// ===== tb/sv/tb_thermistor_table_temperature.sv =====
`timescale 1ns / 1ps

module tb_thermistor_table_temperature;
  import ttt_pkg::*;

  localparam int SettleCycles  = 600;
  localparam int FirstSpareReg = 5;
  localparam int LastSpareReg  = 7;
  localparam int NumPhases     = 13;
  localparam int MaxPrinted    = 40;

  typedef enum logic {
    OpWrite   = 1'b0,
    OpConvert = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [13:0] temperature;
    logic [8:0]         position;
    logic [31:0]        resistance;
    status_e            status;
  } reading_t;

  typedef struct {
    op_e         op;
    logic [8:0]  addr;
    logic [31:0] val;
    logic [15:0] mv;
    bit          fixed;
    reading_t    res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cfg_t        cfg_now;
  logic [31:0] ntc_table [TableDepth];
  reading_t    awaited_readings [$];
  stim_row_t   directed_rows [$];
  int          mismatches = 0;
  int          send_idle_pct = 6;
  int          recv_idle_pct = 74;

  // per-phase register settings and request counts
  int ph_div  [NumPhases] = '{10000, 10000, 1, 16777215, 4700, 100000, 10000, 1000,
                              1000000, 33000, 10000, 2200, 7};
  int ph_sup  [NumPhases] = '{5000, 3300, 65535, 65535, 1, 3300, 5000, 12000, 2500,
                              5000, 5000, 3000, 60000};
  int ph_low  [NumPhases] = '{-55, -40, -512, 511, 0, -20, -55, 100, -300, 511, 0,
                              -55, 200};
  int ph_step [NumPhases] = '{1, 2, 16, 31, 0, 5, 1, 3, 7, 31, 2, 4, 9};
  int ph_ent  [NumPhases] = '{0, 3, 8, 17, 5, 40, 100, 12, 64, 1023, 1, 24, 6};
  int ph_desc [NumPhases] = '{1, 0, 1, 0, 1, 1, 0, 1, 0, 1, 0, 1, 0};
  int ph_conv [NumPhases] = '{25, 35, 40, 50, 25, 70, 70, 60, 70, 40, 35, 70, 60};

  thermistor_table_temperature uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk_i = ~clk_i;

  function automatic int entries_used();
    int n;
    n = int'(cfg_now.entries);
    if (n < 2) n = 2;
    if (n > TableDepth) n = TableDepth;
    return n;
  endfunction

  function automatic logic [31:0] divider_resistance(input logic [15:0] mv);
    logic [63:0] numer;
    logic [63:0] r;
    if (mv >= cfg_now.supply_mv) return 32'hFFFF_FFFF;
    numer = 64'(cfg_now.divider_ohms) * 64'(mv) * 64'd16;
    r = numer / (64'(cfg_now.supply_mv) - 64'(mv));
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    return r[31:0];
  endfunction

  function automatic reading_t predict_reading(input logic [15:0] mv);
    reading_t    res;
    logic [63:0] r;
    logic [63:0] r2;
    logic [63:0] sum;
    logic        desc;
    logic        outside;
    logic        found;
    int          n;
    int          pos;
    longint      t;
    n = entries_used();
    r = 64'(divider_resistance(mv));
    res.status = (mv >= cfg_now.supply_mv) ? StatSupply : StatOk;
    desc = ntc_table[0] > ntc_table[1];
    if (desc) outside = (r > 64'(ntc_table[0])) || (r < 64'(ntc_table[n-1]));
    else outside = (r < 64'(ntc_table[0])) || (r > 64'(ntc_table[n-1]));
    if (outside && res.status == StatOk) res.status = StatRange;
    // first position whose midpoint with its successor lies past r
    r2 = r << 1;
    pos = n - 1;
    found = 1'b0;
    for (int i = 0; i + 1 < n; i++) begin
      sum = 64'(ntc_table[i]) + 64'(ntc_table[i+1]);
      if (!found && (desc ? (r2 > sum) : (r2 < sum))) begin
        pos = i;
        found = 1'b1;
      end
    end
    t = longint'(cfg_now.low_temp) + longint'(pos) * longint'(cfg_now.temp_step);
    if (t > TempMax) t = TempMax;
    if (t < TempMin) t = TempMin;
    res.temperature = 14'(t);
    res.position = 9'(pos);
    res.resistance = r[31:0];
    return res;
  endfunction

  function automatic stim_row_t stim_row(input op_e op, input int addr, input logic [31:0] val,
                                         input int mv, input bit fixed, input int temp,
                                         input int pos, input logic [31:0] res,
                                         input status_e st);
    stim_row_t row;
    row.op = op;
    row.addr = 9'(addr);
    row.val = val;
    row.mv = 16'(mv);
    row.fixed = fixed;
    row.res.temperature = 14'(temp);
    row.res.position = 9'(pos);
    row.res.resistance = res;
    row.res.status = st;
    return row;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < MaxPrinted) $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // entered and left at a falling edge
  task automatic apb_write(input int idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegDivider: cfg_now.divider_ohms = value[23:0];
      RegSupply:  cfg_now.supply_mv = value[15:0];
      RegLowTemp: cfg_now.low_temp = value[9:0];
      RegStep:    cfg_now.temp_step = value[4:0];
      RegEntries: cfg_now.entries = value[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_request(input op_e op, input logic [8:0] addr, input logic [31:0] val,
                              input logic [15:0] mv, input bit fixed, input reading_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'b0, mv, val, addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OpWrite) ntc_table[addr] = val;
    else awaited_readings.push_back(fixed ? res : predict_reading(mv));
    @(negedge clk_i);
  endtask

  // entered right after a request was taken, so the sender goes quiet here
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_readings.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // receiver side
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin : watch_readings
    reading_t want;
    reading_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.temperature = m_axis_tdata[13:0];
      got.position = m_axis_tdata[22:14];
      got.resistance = m_axis_tdata[54:23];
      got.status = status_e'(m_axis_tdata[56:55]);
      if (awaited_readings.size() == 0) begin
        flag_mismatch("reading with no convert request pending");
      end else begin
        want = awaited_readings.pop_front();
        if (got.temperature != want.temperature)
          flag_mismatch($sformatf("temperature %0d, wanted %0d", got.temperature,
                                  want.temperature));
        if (got.position != want.position)
          flag_mismatch($sformatf("table_position %0d, wanted %0d", got.position,
                                  want.position));
        if (got.resistance != want.resistance)
          flag_mismatch($sformatf("resistance %0h, wanted %0h", got.resistance,
                                  want.resistance));
        if (got.status != want.status)
          flag_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    reading_t    none;
    int          n;
    int          s;
    int          pick;
    logic [15:0] mv;
    logic [15:0] cell_mv;
    none = '0;
    cfg_now.divider_ohms = 24'd10000;
    cfg_now.supply_mv = 16'd5000;
    cfg_now.low_temp = -10'sd55;
    cfg_now.temp_step = 5'd1;
    cfg_now.entries = 10'd356;
    foreach (ntc_table[i]) ntc_table[i] = '0;

    // descending table, then broken, then descending again, then ascending
    directed_rows.push_back(stim_row(OpWrite, 0, 32'd4000000, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpWrite, 1, 32'd1600000, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpWrite, 2, 32'd160000, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpWrite, 3, 32'd16000, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 2500, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 5000, 1, -55, 0, 32'hFFFF_FFFF,
                                     StatSupply));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 65535, 1, -55, 0, 32'hFFFF_FFFF,
                                     StatSupply));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 0, 1, -52, 3, 0, StatRange));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 4999, 1, -55, 0, 32'd799840000,
                                     StatRange));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 1000, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 100, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpWrite, 3, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 2500, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpWrite, 511, 32'd0, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpWrite, 256, 32'h5A5A_5A5A, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpWrite, 3, 32'd16000, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 4000, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 1, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpWrite, 0, 32'd16000, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpWrite, 1, 32'd160000, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpWrite, 2, 32'd1600000, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpWrite, 3, 32'd4000000, 0, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 2500, 0, 0, 0, 0, StatOk));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 0, 1, -55, 0, 0, StatRange));
    directed_rows.push_back(stim_row(OpConvert, 0, 0, 5000, 1, -52, 3, 32'hFFFF_FFFF,
                                     StatSupply));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    apb_write(RegEntries, 32'd4);
    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].val,
                   directed_rows[i].mv, directed_rows[i].fixed, directed_rows[i].res);

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      if (p < 4) begin
        send_idle_pct = 6;
        recv_idle_pct = 74;
      end else if (p < 9) begin
        send_idle_pct = 74;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0)
        for (int r = FirstSpareReg; r <= LastSpareReg; r++) apb_write(r, $urandom);
      apb_write(RegDivider, 32'(ph_div[p]));
      apb_write(RegSupply, 32'(ph_sup[p]));
      apb_write(RegLowTemp, 32'(ph_low[p]));
      apb_write(RegStep, 32'(ph_step[p]));
      apb_write(RegEntries, 32'(ph_ent[p]));

      // monotonic table from resistances at rising cell voltages
      n = entries_used();
      s = int'(cfg_now.supply_mv);
      for (int k = 0; k < n; k++) begin
        cell_mv = 16'((k * s + $urandom_range(s - 1, 0)) / n);
        send_request(OpWrite, 9'(ph_desc[p] != 0 ? n - 1 - k : k),
                     divider_resistance(cell_mv), 16'd0, 1'b0, none);
      end

      for (int k = 0; k < ph_conv[p]; k++) begin
        if ($urandom_range(99) < 5)
          send_request(OpWrite, 9'($urandom_range(TableDepth - 1)), $urandom, 16'($urandom),
                       1'b0, none);
        pick = $urandom_range(99);
        if (pick < 8) mv = 16'($urandom_range(65535, s));
        else if (pick < 12) mv = 16'($urandom);
        else mv = 16'($urandom_range(s - 1, 0));
        send_request(OpConvert, 9'($urandom), $urandom, mv, 1'b0, none);
      end
    end

    wait_idle();
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
